[rtl/nptt_pkg.sv]
`timescale 1ns / 1ps

package nptt_pkg;

  localparam int unsigned DUR_W = 46;  // 65535 s in ns fits in 46 bits

  localparam logic [15:0]      ISAKMP_PORT = 16'd500;
  localparam logic [15:0]      ESP_PORT    = 16'd4500;
  localparam logic [62:0]      TIME_MAX    = '1;
  localparam logic [DUR_W-1:0] NS_PER_S    = DUR_W'(64'd1000000000);
  localparam logic [15:0]      IV_RESET    = 16'd20;
  localparam logic [DUR_W-1:0] DUR_RESET   = DUR_W'(64'd20000000000);

  typedef enum logic [1:0] {
    OP_ESTABLISH = 2'd0,
    OP_OBSERVE   = 2'd1,
    OP_OUTBOUND  = 2'd2,
    OP_POLL      = 2'd3
  } nptt_op_e;

  typedef enum logic [2:0] {
    UPD_UNAVAIL     = 3'd0,
    UPD_WRONG_FAM   = 3'd1,
    UPD_WRONG_LOCAL = 3'd2,
    UPD_UNCHANGED   = 3'd3,
    UPD_UNVALIDATED = 3'd4,
    UPD_LOCAL_NAT   = 3'd5,
    UPD_UPDATED     = 3'd6
  } nptt_upd_e;

  typedef struct packed {
    nptt_op_e    opcode;
    logic        is_ipv6;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        local_nat_flag;
    logic        peer_nat_flag;
    logic        authenticated_new;
    logic [62:0] now_ns;
  } nptt_in_t;

  typedef struct packed {
    logic      op_ok;
    nptt_upd_e path_update;
    logic      send_keepalive;
    logic      established_now;
    logic      keepalive_armed_now;
  } nptt_out_t;

  // keepalive settings handed from the config register to the path logic
  typedef struct packed {
    logic             en;   // interval nonzero
    logic [DUR_W-1:0] dur;  // interval in ns
  } nptt_ka_t;

endpackage

[rtl/nptt_cfg.sv]
`timescale 1ns / 1ps

module nptt_cfg import nptt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output nptt_ka_t    ka_o
);

  logic             en_q, en_d;
  logic [DUR_W-1:0] dur_q, dur_d;

  assign cfg_ready_o = 1'b1;

  // seconds to ns done once per write, so the item path only adds
  always_comb begin
    en_d  = en_q;
    dur_d = dur_q;
    if (cfg_valid_i) begin
      en_d  = (cfg_data_i != '0);
      dur_d = DUR_W'(cfg_data_i) * NS_PER_S;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= (IV_RESET != '0);
      dur_q <= DUR_RESET;
    end else begin
      en_q  <= en_d;
      dur_q <= dur_d;
    end
  end

  assign ka_o.en  = en_q;
  assign ka_o.dur = dur_q;

endmodule

[rtl/nptt_path.sv]
`timescale 1ns / 1ps

module nptt_path import nptt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  nptt_in_t  item_i,
  input  nptt_ka_t  ka_i,
  output nptt_out_t res_o
);

  logic        est_q, est_d;
  logic        nat_on_q, nat_on_d;
  logic        lb_q, lb_d;
  logic        pb_q, pb_d;
  logic        armed_q, armed_d;
  logic        fam_v6_q, fam_v6_d;
  logic [63:0] loc_hi_q, loc_hi_d, loc_lo_q, loc_lo_d;
  logic [63:0] rem_hi_q, rem_hi_d, rem_lo_q, rem_lo_d;
  logic [15:0] loc_port_q, loc_port_d;
  logic [15:0] rem_port_q, rem_port_d;
  logic [62:0] deadline_q, deadline_d;

  logic [63:0] sum;
  logic        ovf, arm_en, arm_set, arm_ok;
  logic [62:0] arm_deadline;
  logic        port_ok, nat, loc_eq, rem_eq;

  // one add: now + interval; bit 63 set means past maximum time
  assign sum          = {1'b0, item_i.now_ns} + 64'(ka_i.dur);
  assign ovf          = sum[63];
  assign arm_en       = ka_i.en & ((item_i.opcode == OP_ESTABLISH) ?
                                   item_i.local_nat_flag : (nat_on_q & lb_q));
  assign arm_set      = arm_en & ~ovf;
  assign arm_ok       = ~arm_en | ~ovf;
  assign arm_deadline = arm_set ? sum[62:0] : TIME_MAX;

  assign port_ok = ((item_i.dst_port == ISAKMP_PORT) || (item_i.dst_port == ESP_PORT)) &&
                   (item_i.src_port != '0);
  assign nat     = item_i.local_nat_flag | item_i.peer_nat_flag;

  // IPv4 compares the low 32 bits only
  assign loc_eq = item_i.is_ipv6 ?
                  ((item_i.dst_addr_hi == loc_hi_q) && (item_i.dst_addr_lo == loc_lo_q)) :
                  (item_i.dst_addr_lo[31:0] == loc_lo_q[31:0]);
  assign rem_eq = item_i.is_ipv6 ?
                  ((item_i.src_addr_hi == rem_hi_q) && (item_i.src_addr_lo == rem_lo_q)) :
                  (item_i.src_addr_lo[31:0] == rem_lo_q[31:0]);

  always_comb begin
    est_d      = est_q;
    nat_on_d   = nat_on_q;
    lb_d       = lb_q;
    pb_d       = pb_q;
    armed_d    = armed_q;
    fam_v6_d   = fam_v6_q;
    loc_hi_d   = loc_hi_q;
    loc_lo_d   = loc_lo_q;
    rem_hi_d   = rem_hi_q;
    rem_lo_d   = rem_lo_q;
    loc_port_d = loc_port_q;
    rem_port_d = rem_port_q;
    deadline_d = deadline_q;
    res_o.op_ok          = 1'b0;
    res_o.path_update    = UPD_UNAVAIL;
    res_o.send_keepalive = 1'b0;

    unique case (item_i.opcode)
      OP_ESTABLISH: begin
        if (!est_q && port_ok) begin
          fam_v6_d   = item_i.is_ipv6;
          loc_hi_d   = item_i.dst_addr_hi;
          loc_lo_d   = item_i.dst_addr_lo;
          rem_hi_d   = item_i.src_addr_hi;
          rem_lo_d   = item_i.src_addr_lo;
          loc_port_d = nat ? ESP_PORT : item_i.dst_port;
          rem_port_d = nat ? ESP_PORT : item_i.src_port;
          nat_on_d   = nat;
          lb_d       = item_i.local_nat_flag;
          pb_d       = item_i.peer_nat_flag;
          armed_d    = arm_set;
          deadline_d = arm_deadline;
          est_d      = arm_ok;
          res_o.op_ok = arm_ok;
        end
      end
      OP_OBSERVE: begin
        if (!est_q) begin
          res_o.path_update = UPD_UNAVAIL;
        end else if (item_i.is_ipv6 != fam_v6_q) begin
          res_o.path_update = UPD_WRONG_FAM;
        end else if (!loc_eq || (item_i.dst_port != loc_port_q) ||
                     (item_i.src_port == '0)) begin
          res_o.path_update = UPD_WRONG_LOCAL;
        end else if (rem_eq && (item_i.src_port == rem_port_q)) begin
          armed_d    = arm_set;
          deadline_d = arm_deadline;
          res_o.path_update = UPD_UNCHANGED;
        end else if (!item_i.authenticated_new) begin
          res_o.path_update = UPD_UNVALIDATED;
        end else if (lb_q) begin
          res_o.path_update = UPD_LOCAL_NAT;
        end else begin
          rem_hi_d   = item_i.src_addr_hi;
          rem_lo_d   = item_i.src_addr_lo;
          rem_port_d = item_i.src_port;
          armed_d    = arm_set;
          deadline_d = arm_deadline;
          res_o.path_update = UPD_UPDATED;
        end
      end
      OP_OUTBOUND: begin
        if (est_q) begin
          armed_d    = arm_set;
          deadline_d = arm_deadline;
        end
      end
      OP_POLL: begin
        if (est_q && armed_q && (item_i.now_ns >= deadline_q)) begin
          armed_d    = arm_set;
          deadline_d = arm_deadline;
          res_o.op_ok          = arm_ok;
          res_o.send_keepalive = arm_ok;
        end
      end
      default: ;
    endcase

    res_o.established_now     = est_d;
    res_o.keepalive_armed_now = armed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q      <= 1'b0;
      nat_on_q   <= 1'b0;
      lb_q       <= 1'b0;
      pb_q       <= 1'b0;
      armed_q    <= 1'b0;
      fam_v6_q   <= 1'b0;
      loc_hi_q   <= '0;
      loc_lo_q   <= '0;
      rem_hi_q   <= '0;
      rem_lo_q   <= '0;
      loc_port_q <= '0;
      rem_port_q <= '0;
      deadline_q <= TIME_MAX;
    end else if (fire_i) begin
      est_q      <= est_d;
      nat_on_q   <= nat_on_d;
      lb_q       <= lb_d;
      pb_q       <= pb_d;
      armed_q    <= armed_d;
      fam_v6_q   <= fam_v6_d;
      loc_hi_q   <= loc_hi_d;
      loc_lo_q   <= loc_lo_d;
      rem_hi_q   <= rem_hi_d;
      rem_lo_q   <= rem_lo_d;
      loc_port_q <= loc_port_d;
      rem_port_q <= rem_port_d;
      deadline_q <= deadline_d;
    end
  end

endmodule

[rtl/nat_t_peer_path_tracker_top.sv]
`timescale 1ns / 1ps
// Pipeline: an input word goes through the input register, then the result
//   register, from which its result word is offered.
// Throughput: one word per cycle unless out_ready_i stalls; the path state
//   is updated per word, so consecutive words see each other's updates.
// Reset: asynchronous, active low; path unestablished, keepalive disarmed,
//   deadline at maximum time, keepalive interval 20 s.

module nat_t_peer_path_tracker_top import nptt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  nptt_in_t    in_data_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output nptt_out_t   out_data_o,
  // keepalive interval register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic      in_valid_q, in_valid_d;
  nptt_in_t  in_q;
  logic      out_valid_q, out_valid_d;
  nptt_out_t out_q;
  logic      fire, take;
  nptt_ka_t  ka;
  nptt_out_t res;

  // A held word moves on when the result slot is free or drains this cycle;
  // the input stage refills in the same cycle it empties.
  assign fire       = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | fire;
  assign take       = in_valid_i & in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  // interval register, stored pre-scaled to ns
  nptt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .ka_o        (ka)
  );

  // path state and per-word grading
  nptt_path u_path (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .ka_i   (ka),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[tb/nptt_path_checker.sv]
`timescale 1ns / 1ps

module nptt_path_checker import nptt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  nptt_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  nptt_out_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);

  localparam logic [63:0] NS_IN_S = 64'd1_000_000_000;

  // predicted path state
  logic [15:0] ka_interval_s = IV_RESET;
  logic        established   = 1'b0;
  logic        natt_on       = 1'b0;
  logic        loc_behind    = 1'b0;
  logic        ka_armed      = 1'b0;
  logic        fam_v6        = 1'b0;
  logic [63:0] loc_addr_hi   = '0;
  logic [63:0] loc_addr_lo   = '0;
  logic [63:0] rem_addr_hi   = '0;
  logic [63:0] rem_addr_lo   = '0;
  logic [15:0] loc_port      = '0;
  logic [15:0] rem_port      = '0;
  logic [62:0] deadline      = TIME_MAX;

  nptt_out_t   expected_q[$];
  int unsigned err_cnt = 0;

  assign mismatches_o = err_cnt;

  // IPv4 compares only the low 32 bits of the low word
  function automatic logic addr_match(input logic v6, input logic [63:0] a_hi,
                                      input logic [63:0] a_lo, input logic [63:0] b_hi,
                                      input logic [63:0] b_lo);
    if (v6) return (a_hi == b_hi) && (a_lo == b_lo);
    return a_lo[31:0] == b_lo[31:0];
  endfunction

  function automatic logic rearm_keepalive(input logic [62:0] now);
    logic [63:0] span;
    span = 64'(ka_interval_s) * NS_IN_S;
    ka_armed = natt_on && loc_behind && (ka_interval_s != '0);
    if (!ka_armed) begin
      deadline = TIME_MAX;
      return 1'b1;
    end
    if (64'(now) > 64'(TIME_MAX) - span) begin
      ka_armed = 1'b0;
      deadline = TIME_MAX;
      return 1'b0;
    end
    deadline = now + span[62:0];
    return 1'b1;
  endfunction

  function automatic nptt_out_t track_path(input nptt_in_t w);
    nptt_out_t r;
    logic      nat;
    r = '0;
    r.path_update = UPD_UNAVAIL;
    case (w.opcode)
      OP_ESTABLISH: begin
        if (!established && (w.dst_port == ISAKMP_PORT || w.dst_port == ESP_PORT) &&
            w.src_port != '0) begin
          nat         = w.local_nat_flag | w.peer_nat_flag;
          fam_v6      = w.is_ipv6;
          loc_addr_hi = w.dst_addr_hi;
          loc_addr_lo = w.dst_addr_lo;
          rem_addr_hi = w.src_addr_hi;
          rem_addr_lo = w.src_addr_lo;
          loc_port    = nat ? ESP_PORT : w.dst_port;
          rem_port    = nat ? ESP_PORT : w.src_port;
          natt_on     = nat;
          loc_behind  = w.local_nat_flag;
          established = 1'b1;
          if (rearm_keepalive(w.now_ns)) begin
            r.op_ok = 1'b1;
          end else begin
            established = 1'b0;
          end
        end
      end
      OP_OBSERVE: begin
        if (!established) begin
          r.path_update = UPD_UNAVAIL;
        end else if (w.is_ipv6 != fam_v6) begin
          r.path_update = UPD_WRONG_FAM;
        end else if (!addr_match(w.is_ipv6, loc_addr_hi, loc_addr_lo, w.dst_addr_hi,
                                 w.dst_addr_lo) ||
                     w.dst_port != loc_port || w.src_port == '0) begin
          r.path_update = UPD_WRONG_LOCAL;
        end else if (addr_match(w.is_ipv6, rem_addr_hi, rem_addr_lo, w.src_addr_hi,
                                w.src_addr_lo) && w.src_port == rem_port) begin
          void'(rearm_keepalive(w.now_ns));
          r.path_update = UPD_UNCHANGED;
        end else if (!w.authenticated_new) begin
          r.path_update = UPD_UNVALIDATED;
        end else if (loc_behind) begin
          r.path_update = UPD_LOCAL_NAT;
        end else begin
          rem_addr_hi = w.src_addr_hi;
          rem_addr_lo = w.src_addr_lo;
          rem_port    = w.src_port;
          void'(rearm_keepalive(w.now_ns));
          r.path_update = UPD_UPDATED;
        end
      end
      OP_OUTBOUND: begin
        if (established) void'(rearm_keepalive(w.now_ns));
      end
      default: begin
        if (established && ka_armed && w.now_ns >= deadline) begin
          if (rearm_keepalive(w.now_ns)) begin
            r.op_ok          = 1'b1;
            r.send_keepalive = 1'b1;
          end
        end
      end
    endcase
    r.established_now     = established;
    r.keepalive_armed_now = ka_armed;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [2:0] want,
                             input logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nptt_out_t want;
    if (!rst_ni) begin
      ka_interval_s = IV_RESET;
      established   = 1'b0;
      natt_on       = 1'b0;
      loc_behind    = 1'b0;
      ka_armed      = 1'b0;
      fam_v6        = 1'b0;
      loc_addr_hi   = '0;
      loc_addr_lo   = '0;
      rem_addr_hi   = '0;
      rem_addr_lo   = '0;
      loc_port      = '0;
      rem_port      = '0;
      deadline      = TIME_MAX;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result word with no word expected");
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          check_field("op_ok", 3'(want.op_ok), 3'(out_data_i.op_ok));
          check_field("path_update", 3'(want.path_update), 3'(out_data_i.path_update));
          check_field("send_keepalive", 3'(want.send_keepalive),
                      3'(out_data_i.send_keepalive));
          check_field("established_now", 3'(want.established_now),
                      3'(out_data_i.established_now));
          check_field("keepalive_armed_now", 3'(want.keepalive_armed_now),
                      3'(out_data_i.keepalive_armed_now));
        end
      end
      if (cfg_valid_i && cfg_ready_i) ka_interval_s = cfg_data_i;
      if (in_valid_i && in_ready_i) expected_q.push_back(track_path(in_data_i));
      pending_o <= expected_q.size();
    end
  end

endmodule

[tb/tb_nat_t_peer_path_tracker_top.sv]
`timescale 1ns / 1ps

module tb_nat_t_peer_path_tracker_top import nptt_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned PHASE_WORDS = 200;
  localparam logic [63:0] NS_IN_S     = 64'd1_000_000_000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  nptt_in_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  nptt_out_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;

  int unsigned pending;
  int unsigned mismatches;

  // What the stimulus side knows about the path, so that most observe words
  // hit the recorded tuple. peers[] holds candidate remote endpoints; the
  // slot holding the current remote is never overwritten.
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
  } endpoint_t;

  endpoint_t   peers[4];
  int unsigned cur_peer;
  logic        path_v6;
  logic        path_lnat;
  logic [63:0] loc_hi;
  logic [63:0] loc_lo;
  logic [15:0] loc_port;
  logic [63:0] clock_ns;   // monotonic time base for most words
  logic [15:0] iv_s;       // interval last written, sizes the time steps
  bit          tx_burst;   // sender runs without gaps
  bit          rx_burst;   // receiver never stalls

  always #5 clk_i = ~clk_i;

  nat_t_peer_path_tracker_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  nptt_path_checker u_path_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // every field random; callers overwrite what matters
  function automatic nptt_in_t noise_word();
    nptt_in_t w;
    w.opcode            = nptt_op_e'($urandom_range(0, 3));
    w.is_ipv6           = 1'($urandom);
    w.src_addr_hi       = rand64();
    w.src_addr_lo       = rand64();
    w.dst_addr_hi       = rand64();
    w.dst_addr_lo       = rand64();
    w.src_port          = 16'($urandom);
    w.dst_port          = 16'($urandom);
    w.local_nat_flag    = 1'($urandom);
    w.peer_nat_flag     = 1'($urandom);
    w.authenticated_new = 1'($urandom);
    w.now_ns            = 63'(rand64());
    return w;
  endfunction

  // Time for the next word. Mostly a forward step on the time base: small,
  // up to two intervals, or exactly one interval so polls land on the
  // deadline. A few words sit just under maximum time (deadline overflow)
  // and a few carry any 63-bit value.
  function automatic logic [62:0] next_now();
    logic [63:0] span;
    int unsigned r;
    span = 64'(iv_s) * NS_IN_S;
    r = $urandom_range(0, 99);
    if (r < 4) return TIME_MAX - 63'(rand64() % (span + 64'd2));
    if (r < 6) return 63'(rand64());
    r = $urandom_range(0, 9);
    if (r < 5) begin
      clock_ns += 64'($urandom_range(0, 1000));
    end else if (r < 8) begin
      clock_ns += rand64() % (2 * span + 64'd2);
    end else begin
      clock_ns += span;
    end
    return 63'(clock_ns);
  endfunction

  // Observe word aimed at the recorded path. slot < 0 draws a fresh remote
  // endpoint into a free slot. flaw: 0 none, 1 wrong family, 2 wrong local
  // address, 3 wrong local port, 4 zero source port.
  function automatic nptt_in_t observe_word(input int slot, input int unsigned flaw,
                                            input logic auth, input logic [62:0] now);
    nptt_in_t    w;
    int unsigned s;
    int unsigned b;
    w = noise_word();
    if (slot < 0) begin
      s = (cur_peer + $urandom_range(1, 3)) % 4;
      peers[s] = '{hi: rand64(), lo: rand64(), port: 16'($urandom_range(1, 65535))};
    end else begin
      s = slot;
    end
    w.opcode            = OP_OBSERVE;
    w.is_ipv6           = path_v6;
    w.authenticated_new = auth;
    w.now_ns            = now;
    w.dst_port          = loc_port;
    w.src_port          = peers[s].port;
    // IPv4 ignores the upper bits, so they stay random
    w.dst_addr_hi = path_v6 ? loc_hi : rand64();
    w.dst_addr_lo = path_v6 ? loc_lo : {$urandom, loc_lo[31:0]};
    w.src_addr_hi = path_v6 ? peers[s].hi : rand64();
    w.src_addr_lo = path_v6 ? peers[s].lo : {$urandom, peers[s].lo[31:0]};
    case (flaw)
      1: w.is_ipv6 = ~path_v6;
      2: begin
        b = $urandom_range(0, 63);
        if (!path_v6) begin
          w.dst_addr_lo[b % 32] = ~w.dst_addr_lo[b % 32];
        end else if ($urandom_range(0, 1) == 0) begin
          w.dst_addr_hi[b] = ~w.dst_addr_hi[b];
        end else begin
          w.dst_addr_lo[b] = ~w.dst_addr_lo[b];
        end
      end
      3: w.dst_port = loc_port ^ 16'($urandom_range(1, 65535));
      4: w.src_port = '0;
      default: ;
    endcase
    // a validated new message moves the remote unless we sit behind NAT
    if (flaw == 0 && auth && !path_lnat) cur_peer = s;
    return w;
  endfunction

  // Random part mix: observes on the live path (mostly well-formed) as the
  // largest share, plus outbound, polls, stray establishes and fully random words.
  function automatic nptt_in_t random_word();
    nptt_in_t    w;
    int unsigned r;
    int          slot;
    int unsigned flaw;
    logic        auth;
    logic [62:0] now;
    now = next_now();
    r = $urandom_range(0, 99);
    if (r < 42) begin
      if ($urandom_range(0, 5) == 0) begin
        slot = -1;
      end else if ($urandom_range(0, 1) == 0) begin
        slot = cur_peer;
      end else begin
        slot = $urandom_range(0, 3);
      end
      flaw = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 4) : 0;
      auth = ($urandom_range(0, 9) < 7);
      return observe_word(slot, flaw, auth, now);
    end
    w = noise_word();
    w.now_ns = now;
    if (r < 62) begin
      w.opcode = OP_OUTBOUND;
    end else if (r < 87) begin
      w.opcode = OP_POLL;
    end else if (r < 92) begin
      w.opcode   = OP_ESTABLISH;
      w.dst_port = ($urandom_range(0, 1) == 0) ? ISAKMP_PORT : ESP_PORT;
    end
    return w;
  endfunction

  task automatic send_word(input nptt_in_t w);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait until every expected result word is back
  task automatic wait_path_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    iv_s = v;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: may stall before each result word, never in bursts.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  initial begin
    nptt_in_t    w;
    logic [62:0] t1;
    logic [15:0] plan[7];
    int unsigned flaw;
    logic        nat;

    plan     = '{16'hFFFF, 16'd0, 16'd1, 16'($urandom), 16'd20,
                 16'($urandom_range(2, 300)), 16'd3};
    iv_s     = IV_RESET;
    clock_ns = 64'($urandom_range(0, 1 << 30)) * 64'd1000;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    cur_peer = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // --- directed part, interval still at its reset value ---

    // observe, outbound and poll on an idle path
    w = noise_word(); w.opcode = OP_OBSERVE; send_word(w);
    w = noise_word(); w.opcode = OP_OUTBOUND; send_word(w);
    w = noise_word(); w.opcode = OP_POLL; w.now_ns = TIME_MAX; send_word(w);

    // establish refused: bad local port (all-ones tuple), then zero source port
    w = noise_word();
    w.opcode      = OP_ESTABLISH;
    w.src_addr_hi = '1;
    w.src_addr_lo = '1;
    w.dst_addr_hi = '1;
    w.dst_addr_lo = '1;
    w.src_port    = '1;
    w.dst_port    = '1;
    send_word(w);
    w = noise_word();
    w.opcode      = OP_ESTABLISH;
    w.src_addr_hi = '0;
    w.src_addr_lo = '0;
    w.dst_addr_hi = '0;
    w.dst_addr_lo = '0;
    w.src_port    = '0;
    w.dst_port    = ISAKMP_PORT;
    send_word(w);

    // local NAT at maximum time: keepalive deadline overflows, path stays down
    w = noise_word();
    w.opcode         = OP_ESTABLISH;
    w.dst_port       = ESP_PORT;
    w.src_port       = 16'd1;
    w.local_nat_flag = 1'b1;
    w.now_ns         = TIME_MAX;
    send_word(w);
    w = noise_word(); w.opcode = OP_POLL; w.now_ns = TIME_MAX; send_word(w);

    // The establish that sticks. The path can never be torn down again, so
    // family and NAT picture are drawn per run: local NAT gives keepalive
    // traffic, no local NAT lets the remote endpoint move.
    w = noise_word();
    w.opcode   = OP_ESTABLISH;
    w.dst_port = ($urandom_range(0, 1) == 0) ? ISAKMP_PORT : ESP_PORT;
    w.src_port = 16'($urandom_range(1, 65535));
    w.now_ns   = 63'(clock_ns);
    nat        = w.local_nat_flag | w.peer_nat_flag;
    path_v6    = w.is_ipv6;
    path_lnat  = w.local_nat_flag;
    loc_hi     = w.dst_addr_hi;
    loc_lo     = w.dst_addr_lo;
    loc_port   = nat ? ESP_PORT : w.dst_port;
    peers[0]   = '{hi: w.src_addr_hi, lo: w.src_addr_lo,
                   port: nat ? ESP_PORT : w.src_port};
    for (int k = 1; k < 4; k++) begin
      peers[k] = '{hi: rand64(), lo: rand64(), port: 16'($urandom_range(1, 65535))};
    end
    send_word(w);
    send_word(w);  // already established: refused

    // observe rejects: family, local address, local port, zero source port
    for (flaw = 1; flaw <= 4; flaw++) begin
      send_word(observe_word(cur_peer, flaw, 1'b1, 63'(clock_ns)));
    end

    // same tuple rearms; new tuple unvalidated; new tuple validated
    t1 = 63'(clock_ns) + 63'd5;
    send_word(observe_word(cur_peer, 0, 1'b1, t1));
    send_word(observe_word(-1, 0, 1'b0, t1));
    send_word(observe_word(-1, 0, 1'b1, t1));

    // polls: early, then exactly on the deadline
    w = noise_word();
    w.opcode = OP_POLL;
    w.now_ns = t1 + 63'd1;
    send_word(w);
    w.now_ns = t1 + 63'(64'(IV_RESET) * NS_IN_S);
    send_word(w);
    w.opcode = OP_OUTBOUND;
    w.now_ns = w.now_ns + 63'd7;
    send_word(w);

    // poll at maximum time: deadline reached but the rearm overflows, then
    // a poll on the disarmed path
    w.opcode = OP_POLL;
    w.now_ns = TIME_MAX;
    send_word(w);
    send_word(w);

    // unchanged tuple at maximum time: the rearm fails without a report
    send_word(observe_word(cur_peer, 0, 1'b0, TIME_MAX));
    w.opcode = OP_OUTBOUND;
    w.now_ns = t1 + 63'd100;
    send_word(w);
    clock_ns = 64'(t1) + 64'd100;

    // --- random phases, one interval setting each ---
    // each phase starts with the path drained, so the register is written idle
    foreach (plan[p]) begin
      wait_path_idle();
      write_interval(plan[p]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 50 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        send_word(random_word());
      end
    end

    tx_burst = 1'b0;
    rx_burst = 1'b0;
    wait_path_idle();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
